// ----- rtl/gsa_pkg.sv -----
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared widths, stage map, register indexes and exponential tables for the
// gaussian splat adder.
// ----------------------------------------------------------------------------
`default_nettype none

package gsa_pkg;

  localparam int MAX_DIM         = 2048;
  localparam int EXP_TABLE_DEPTH = 256;

  localparam int PIX_W      = 32;
  localparam int COORD_W    = 11;
  localparam int AMP_W      = 32;
  localparam int SCALE_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Q.30 fixed point throughout the exponential path
  localparam int Q         = 30;
  localparam int D2_W      = 2 * COORD_W + 1;
  localparam int T_W       = SCALE_W + D2_W;
  // exp(-t) is zero from t = 32 on, so only t below 2^(Q+5) matters
  localparam int T_LIM_W   = Q + 5;
  localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int EXP_PRD_W = T_LIM_W + EXP_IDX_W;
  localparam int EXP_W     = Q + 1;
  localparam int AMUL_W    = AMP_W + EXP_W;
  localparam int MAG_W     = AMUL_W - Q;
  localparam int SUM_W     = PIX_W + 2;

  // Pipeline stage map
  localparam int ST_DIFF    = 0;
  localparam int ST_D2      = 1;
  localparam int ST_T       = 2;
  localparam int ST_LOOK    = 3;
  localparam int ST_INTERP  = 4;
  localparam int ST_MUL     = 5;
  localparam int ST_OUT     = 6;
  localparam int NUM_STAGES = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_COL     = 2'd0,
    CFG_CENTER_ROW     = 2'd1,
    CFG_PEAK_AMPLITUDE = 2'd2,
    CFG_FALLOFF_SCALE  = 2'd3
  } gsa_cfg_idx_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } gsa_ctl_t;

  typedef logic [EXP_W-1:0] exp_word_t;
  typedef exp_word_t exp_tab_t [EXP_TABLE_DEPTH];

  // Table step in Q.30: one table entry covers 32 / EXP_TABLE_DEPTH of t
  localparam logic [63:0] EXP_X = (64'd32 << Q) / EXP_TABLE_DEPTH;

  // Shift-and-subtract quotient, evaluated at elaboration only
  function automatic logic [63:0] const_udiv(input logic [63:0] num,
                                             input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int          b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Q.30 Taylor sum of exp(EXP_X), stopping at the first zero term
  function automatic logic [63:0] exp_taylor_sum();
    logic [63:0] sum;
    logic [63:0] term;
    int          n;
    sum  = 64'd0;
    term = 64'd1 << Q;
    n    = 1;
    while (term != 64'd0 && n < 64) begin
      sum  = sum + term;
      term = const_udiv(term * EXP_X, 64'(n) << Q);
      n    = n + 1;
    end
    return sum;
  endfunction

  localparam logic [63:0] EXP_SUM   = exp_taylor_sum();
  // Rounded reciprocal: the ratio from one entry to the next
  localparam logic [63:0] EXP_RATIO = ((64'd1 << 60) + (EXP_SUM >> 1)) / EXP_SUM;

  // Build the exp(-k/8) ladder; either the entries themselves or the drop
  // to the next entry, used for linear interpolation.
  function automatic exp_tab_t build_exp_tab(input bit want_delta);
    exp_tab_t    tab;
    logic [63:0] e_cur;
    logic [63:0] e_next;
    logic [63:0] e_low;
    int          k;
    e_cur = 64'd1 << Q;
    for (k = 0; k < EXP_TABLE_DEPTH; k++) begin
      e_next = (e_cur * EXP_RATIO + (64'd1 << (Q - 1))) >> Q;
      e_low  = (e_next > e_cur) ? e_cur : e_next;
      tab[k] = want_delta ? EXP_W'(e_cur - e_low) : EXP_W'(e_cur);
      e_cur  = e_next;
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_HI_TAB    = build_exp_tab(1'b0);
  localparam exp_tab_t EXP_DELTA_TAB = build_exp_tab(1'b1);

endpackage

`default_nettype wire

// ----- rtl/gsa_in_if.sv -----
// ----------------------------------------------------------------------------
// gsa_in_if
// Pixel input channel: valid/ready with pixel value and raster position.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsa_in_if import gsa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PIX_W-1:0]   pixel_in;
  logic        [COORD_W-1:0] col;
  logic        [COORD_W-1:0] row_index;

  modport source (output valid, pixel_in, col, row_index, input ready);
  modport sink   (input valid, pixel_in, col, row_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/gsa_out_if.sv -----
// ----------------------------------------------------------------------------
// gsa_out_if
// Result channel: valid/ready with the updated pixel value.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsa_out_if import gsa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink   (input valid, pixel_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/gsa_geom.sv -----
// ----------------------------------------------------------------------------
// gsa_geom
// Distance stages: clamp and difference, squared distance, scaled exponent.
// ----------------------------------------------------------------------------
`default_nettype none

module gsa_geom import gsa_pkg::*; (
  input  wire logic               clk,
  input  wire gsa_ctl_t           ctl,
  input  wire logic [COORD_W-1:0] center_col,
  input  wire logic [COORD_W-1:0] center_row,
  input  wire logic [SCALE_W-1:0] scale,
  input  wire logic [PIX_W-1:0]   pix_i,
  input  wire logic [COORD_W-1:0] col_i,
  input  wire logic [COORD_W-1:0] row_i,
  output logic      [T_W-1:0]     t_o,
  output logic      [PIX_W-1:0]   pix_o
);

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    if (32'(v) >= MAX_DIM) begin
      return COORD_W'(MAX_DIM - 1);
    end
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  logic [COORD_W-1:0]   dx_r, dx_nxt, dy_r, dy_nxt;
  logic [D2_W-1:0]      d2_r, d2_nxt;
  logic [T_W-1:0]       t_r, t_nxt;
  logic [PIX_W-1:0]     pix_a_r, pix_b_r, pix_c_r;
  logic [2*COORD_W-1:0] sqx, sqy;

  always_comb begin
    dx_nxt = abs_diff(clamp_coord(col_i), clamp_coord(center_col));
    dy_nxt = abs_diff(clamp_coord(row_i), clamp_coord(center_row));
    sqx    = (2*COORD_W)'(dx_r) * (2*COORD_W)'(dx_r);
    sqy    = (2*COORD_W)'(dy_r) * (2*COORD_W)'(dy_r);
    d2_nxt = D2_W'(sqx) + D2_W'(sqy);
    t_nxt  = T_W'(scale) * T_W'(d2_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[ST_DIFF]) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      pix_a_r <= pix_i;
    end
    if (ctl.en[ST_D2]) begin
      d2_r    <= d2_nxt;
      pix_b_r <= pix_a_r;
    end
    if (ctl.en[ST_T]) begin
      t_r     <= t_nxt;
      pix_c_r <= pix_b_r;
    end
  end

  assign t_o   = t_r;
  assign pix_o = pix_c_r;

endmodule

`default_nettype wire

// ----- rtl/gsa_exp.sv -----
// ----------------------------------------------------------------------------
// gsa_exp
// exp(-t) stages: table lookup, then linear interpolation between entries.
// ----------------------------------------------------------------------------
`default_nettype none

module gsa_exp import gsa_pkg::*; (
  input  wire logic             clk,
  input  wire gsa_ctl_t         ctl,
  input  wire logic [T_W-1:0]   t_i,
  input  wire logic [PIX_W-1:0] pix_i,
  output logic      [EXP_W-1:0] e_o,
  output logic      [PIX_W-1:0] pix_o
);

  logic [EXP_PRD_W-1:0]   pos_full;
  logic [EXP_PRD_W-6:0]   pos;
  logic [EXP_IDX_W-1:0]   idx;
  logic                   far_r, far_nxt;
  logic [EXP_W-1:0]       hi_r, hi_nxt, delta_r, delta_nxt;
  logic [Q-1:0]           frac_r, frac_nxt;
  logic [EXP_W+Q-1:0]     drop;
  logic [EXP_W-1:0]       e_r, e_nxt;
  logic [PIX_W-1:0]       pix_a_r, pix_b_r;

  always_comb begin
    far_nxt   = |t_i[T_W-1:T_LIM_W];
    pos_full  = EXP_PRD_W'(t_i[T_LIM_W-1:0]) * EXP_PRD_W'(EXP_TABLE_DEPTH);
    pos       = pos_full[EXP_PRD_W-1:5];
    idx       = pos[Q+EXP_IDX_W-1:Q];
    frac_nxt  = pos[Q-1:0];
    hi_nxt    = EXP_HI_TAB[idx];
    delta_nxt = EXP_DELTA_TAB[idx];
    drop      = (EXP_W+Q)'(delta_r) * (EXP_W+Q)'(frac_r);
    e_nxt     = far_r ? '0 : (hi_r - EXP_W'(drop >> Q));
  end

  always_ff @(posedge clk) begin
    if (ctl.en[ST_LOOK]) begin
      far_r   <= far_nxt;
      hi_r    <= hi_nxt;
      delta_r <= delta_nxt;
      frac_r  <= frac_nxt;
      pix_a_r <= pix_i;
    end
    if (ctl.en[ST_INTERP]) begin
      e_r     <= e_nxt;
      pix_b_r <= pix_a_r;
    end
  end

  assign e_o   = e_r;
  assign pix_o = pix_b_r;

endmodule

`default_nettype wire

// ----- rtl/gsa_scale.sv -----
// ----------------------------------------------------------------------------
// gsa_scale
// Amplitude stages: magnitude times exponential, round, add and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module gsa_scale import gsa_pkg::*; (
  input  wire logic             clk,
  input  wire gsa_ctl_t         ctl,
  input  wire logic [EXP_W-1:0] e_i,
  input  wire logic [PIX_W-1:0] pix_i,
  input  wire logic             amp_neg,
  input  wire logic [AMP_W-1:0] amp_mag,
  output logic      [PIX_W-1:0] pixel_out
);

  logic [AMUL_W-1:0] prod_r, prod_nxt;
  logic [PIX_W-1:0]  pix_r;
  logic [MAG_W-1:0]  mag;
  logic [SUM_W-1:0]  pix_ext, mag_ext, sum;
  logic [PIX_W-1:0]  out_r, out_nxt;

  always_comb begin
    prod_nxt = AMUL_W'(amp_mag) * AMUL_W'(e_i);
    // round half away from zero on the magnitude
    mag      = MAG_W'((prod_r + (AMUL_W'(1) << (Q - 1))) >> Q);
    pix_ext  = {{(SUM_W-PIX_W){pix_r[PIX_W-1]}}, pix_r};
    mag_ext  = SUM_W'(mag);
    sum      = amp_neg ? (pix_ext - mag_ext) : (pix_ext + mag_ext);
    if (sum[SUM_W-1:PIX_W-1] == '0 || sum[SUM_W-1:PIX_W-1] == '1) begin
      out_nxt = sum[PIX_W-1:0];
    end else if (sum[SUM_W-1]) begin
      out_nxt = {1'b1, {(PIX_W-1){1'b0}}};
    end else begin
      out_nxt = {1'b0, {(PIX_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[ST_MUL]) begin
      prod_r <= prod_nxt;
      pix_r  <= pix_i;
    end
    if (ctl.en[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign pixel_out = out_r;

endmodule

`default_nettype wire

// ----- rtl/gaussian_splat_add_unit.sv -----
// ----------------------------------------------------------------------------
// gaussian_splat_add_unit
// Adds a configured gaussian bump to a stream of Q16.16 pixels.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock while not stalled and returns it as
// pixel_in + peak_amplitude * exp(-falloff_scale * d2), saturated to signed
// Q16.16, where d2 is the squared distance from (col, row_index) to the
// configured centre. There are seven register stages: clamp and
// difference, squared distance, exponent multiply, table lookup,
// interpolation, amplitude multiply, and round/add/saturate. Each stage has
// its own valid bit and moves whenever the stage after it is free, so
// bubbles collapse under back-pressure and one transfer per clock is held as
// long as the result side keeps ready high. exp(-t) comes from a 256-entry
// constant table with linear interpolation and is exactly zero from t = 32
// on. Program the four registers only while no pixel is in flight; a write
// takes effect on the next clock.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_splat_add_unit import gsa_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  gsa_in_if.sink                     in_chan,
  gsa_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration; amplitude is kept as sign and magnitude
  logic [COORD_W-1:0] center_col_r, center_row_r;
  logic               amp_neg_r;
  logic [AMP_W-1:0]   amp_mag_r, amp_mag_nxt;
  logic [SCALE_W-1:0] scale_r;

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES:0]   en_chain;
  gsa_ctl_t              ctl;

  logic [T_W-1:0]   t_geo;
  logic [PIX_W-1:0] pix_geo, pix_exp, pix_res;
  logic [EXP_W-1:0] e_exp;

  assign amp_mag_nxt = cfg_wdata[AMP_W-1] ? (~cfg_wdata[AMP_W-1:0] + AMP_W'(1))
                                          : cfg_wdata[AMP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_col_r <= '0;
      center_row_r <= '0;
      amp_neg_r    <= 1'b0;
      amp_mag_r    <= '0;
      scale_r      <= '0;
    end else if (cfg_we) begin
      case (gsa_cfg_idx_t'(cfg_index))
        CFG_CENTER_COL: begin
          center_col_r <= cfg_wdata[COORD_W-1:0];
        end
        CFG_CENTER_ROW: begin
          center_row_r <= cfg_wdata[COORD_W-1:0];
        end
        CFG_PEAK_AMPLITUDE: begin
          amp_neg_r <= cfg_wdata[AMP_W-1];
          amp_mag_r <= amp_mag_nxt;
        end
        CFG_FALLOFF_SCALE: begin
          scale_r <= cfg_wdata[SCALE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // A stage may load when it is empty or when its item moves on this cycle.
  always_comb begin
    en_chain[NUM_STAGES] = out_chan.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en_chain[k] = !valid_r[k] || en_chain[k+1];
    end
    ctl.en = en_chain[NUM_STAGES-1:0];
  end

  // Advance valid bits with the data; hold where the next stage is blocked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en_chain[0]) begin
        valid_r[0] <= in_chan.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en_chain[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  assign in_chan.ready = en_chain[0];

  gsa_geom u_geom (
    .clk        (clk),
    .ctl        (ctl),
    .center_col (center_col_r),
    .center_row (center_row_r),
    .scale      (scale_r),
    .pix_i      (in_chan.pixel_in),
    .col_i      (in_chan.col),
    .row_i      (in_chan.row_index),
    .t_o        (t_geo),
    .pix_o      (pix_geo)
  );

  gsa_exp u_exp (
    .clk   (clk),
    .ctl   (ctl),
    .t_i   (t_geo),
    .pix_i (pix_geo),
    .e_o   (e_exp),
    .pix_o (pix_exp)
  );

  gsa_scale u_scale (
    .clk       (clk),
    .ctl       (ctl),
    .e_i       (e_exp),
    .pix_i     (pix_exp),
    .amp_neg   (amp_neg_r),
    .amp_mag   (amp_mag_r),
    .pixel_out (pix_res)
  );

  // Result transfer comes straight from the last stage register
  assign out_chan.valid     = valid_r[NUM_STAGES-1];
  assign out_chan.pixel_out = pix_res;

endmodule

`default_nettype wire

// ----- rtl/gsa_checker.sv -----
// ----------------------------------------------------------------------------
// gsa_checker
// Port-level checks on the gaussian splat adder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gsa_checker import gsa_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [PIX_W-1:0] pixel_out
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(pixel_out)))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With no result waiting every stage can move, so input is taken
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while pipeline drains freely");

  // Free-running pipeline: a transfer in shows up at the output after passing every stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(in_valid && in_ready && rst_n, 7) &&
     $past(out_ready && rst_n, 1) && $past(out_ready && rst_n, 2) &&
     $past(out_ready && rst_n, 3) && $past(out_ready && rst_n, 4) &&
     $past(out_ready && rst_n, 5) && $past(out_ready && rst_n, 6))
    |-> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind gaussian_splat_add_unit gsa_checker u_gsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .pixel_out (out_chan.pixel_out)
);

`default_nettype wire
